[rtl/core/delimited_string_history_ring_macros.svh]
// Assertion macros for the string history ring checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef DELIMITED_STRING_HISTORY_RING_MACROS_SVH
`define DELIMITED_STRING_HISTORY_RING_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DSHR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dshr: assertion violated");

// next-cycle implication, disabled while reset is asserted
`define DSHR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dshr: assertion violated");

`endif

[rtl/core/dshr_pkg.sv]
// Shared types, constants and ring helpers for the string history ring.
// No dependencies; imported by the top level, sequencer, output register and checker.
`default_nettype none

package dshr_pkg;

	localparam int RING_BYTES = 16;
	localparam int AW         = $clog2(RING_BYTES);
	localparam int CNT_W      = $clog2(RING_BYTES + 1);
	localparam int STP_W      = $clog2(RING_BYTES + 1);
	localparam int SUM_W      = $clog2(RING_BYTES + 16);
	localparam int MOD_STEPS  = (RING_BYTES + 15) / RING_BYTES;
	localparam int MRC_W      = 6;

	localparam logic [MRC_W-1:0] MRC_RESET = 6'd19;
	localparam logic [AW-1:0]    CHR_MAX   = AW'(RING_BYTES - 2);

	localparam logic [7:0] MARK_START = 8'h01;
	localparam logic [7:0] MARK_END   = 8'hFF;
	localparam logic [7:0] CHAR_LOW   = 8'd32;
	localparam logic [7:0] CHAR_HIGH  = 8'd126;
	localparam logic [7:0] CHAR_SUB   = 8'h3F;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;

	typedef enum logic [2:0] {
		CMD_APPEND  = 3'd0,
		CMD_OLDER   = 3'd1,
		CMD_NEWER   = 3'd2,
		CMD_RD_CHAR = 3'd3,
		CMD_RD_STR  = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_BUSY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APP_RD,
		S_APP_WR,
		S_WALK_RD,
		S_WALK_CK,
		S_RCH_CK,
		S_RS_RD,
		S_RS_CK,
		S_RS_FIN,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] char_out;
		logic       last;
	} res_t;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
		return (p == '0) ? AW'(RING_BYTES - 1) : p - AW'(1);
	endfunction

	// reduce a sum below RING_BYTES + 16 into the ring
	function automatic logic [AW-1:0] ring_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = s;
		for (int k = 0; k < MOD_STEPS; k++) begin
			if (r >= SUM_W'(RING_BYTES))
				r = r - SUM_W'(RING_BYTES);
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [7:0] sanitize(input logic [7:0] c);
		return (c < CHAR_LOW || c > CHAR_HIGH) ? CHAR_SUB : c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/delimited_string_history_ring.sv]
// Top level of the string history ring: sequencer, byte store, output register.
// Uses dshr_pkg, dshr_ram, dshr_seq and dshr_obuf.
`default_nettype none

// Keeps a history of text strings in a RING_BYTES byte ring, each stored as
// START 0x01, its characters (unprintable ones as '?') and END 0xFF. Commands
// arrive one transaction at a time on the s_ side and answer on the m_ side;
// a string read answers with one transaction per character, m_tlast on the
// final one. One command is worked on at a time. Every read of the store
// goes through its single registered read port, and each byte is read and
// checked before the next step: a command reads each byte that it touches,
// then checks or writes it, and at last hands over the answer.
// The answer passes through the output register before m_tvalid rises.
// The store needs no clearing pass after reset: valid bits make untouched
// bytes read as zero, and the clear command wipes them all at once.
// While a transaction waits on m_tready, the next command can already be taken.
module delimited_string_history_ring
	import dshr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [7:0] char_in, [11:8] char_offset, pad
	input  wire logic [S_TUSER_W-1:0] s_tuser,  // [2:0] cmd
	input  wire logic                 s_tlast,  // end_of_string
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // [7:0] char_out
	output logic      [M_TUSER_W-1:0] m_tuser,  // [1:0] status
	output logic                      m_tlast,  // last
	input  wire logic                 cfg_we,
	input  wire logic [MRC_W-1:0]     cfg_wdata // max_read_chars
);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [7:0]    mem_wr_data;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [7:0]    mem_rd_data;

	dshr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[2:0]),
		.in_char    (s_tdata[7:0]),
		.in_eos     (s_tlast),
		.in_off     (s_tdata[11:8]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	dshr_ram #(
		.DEPTH(RING_BYTES),
		.WIDTH(8)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	dshr_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[rtl/core/dshr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; sized by its parameters.
`default_nettype none

module dshr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/dshr_seq.sv]
// Command sequencer: read-check-write over the byte store, pointers and counters.
// Uses dshr_pkg; drives the ports of dshr_ram and feeds results to dshr_obuf.
`default_nettype none

module dshr_seq
	import dshr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       in_cmd,
	input  wire logic [7:0]       in_char,
	input  wire logic             in_eos,
	input  wire logic [3:0]       in_off,
	input  wire logic             cfg_we,
	input  wire logic [MRC_W-1:0] cfg_wdata,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res,
	output logic                  mem_wr_en,
	output logic      [AW-1:0]    mem_wr_addr,
	output logic      [7:0]       mem_wr_data,
	output logic                  mem_rd_en,
	output logic      [AW-1:0]    mem_rd_addr,
	input  wire logic [7:0]       mem_rd_data
);

	state_t             state_q, state_d;
	logic [AW-1:0]      ins_q, ins_d;
	logic [AW-1:0]      brw_q, brw_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               open_q, open_d;
	logic [AW-1:0]      chw_q, chw_d;
	logic [MRC_W-1:0]   mrc_q;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [STP_W-1:0]   stp_q, stp_d;
	logic [2:0]         pend_q, pend_d;
	logic [7:0]         chr_q, chr_d;
	logic [MRC_W-1:0]   rsn_q, rsn_d;
	logic [7:0]         held_q, held_d;
	logic               held_v_q, held_v_d;
	logic               older_q, older_d;
	status_t            rst_q, rst_d;
	logic [7:0]         rch_q, rch_d;
	logic [RING_BYTES-1:0] valid_q;
	logic               vld_s1;
	logic               clr_all;

	logic [7:0]         rbyte;
	logic               dec;
	logic [CNT_W-1:0]   cnt_dec;
	logic [2:0]         pend_nx;
	logic [AW-1:0]      step_addr;
	logic [MRC_W-1:0]   limit;
	logic               advance;

	// unwritten entries read as zero
	assign rbyte     = vld_s1 ? mem_rd_data : 8'h00;
	assign dec       = (rbyte == MARK_START) && (cnt_q != '0);
	assign cnt_dec   = cnt_q - CNT_W'(dec);
	assign step_addr = older_q ? ring_prev(ptr_q) : ring_next(ptr_q);
	assign limit     = mrc_q - MRC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ins_q    <= '0;
			brw_q    <= '0;
			cnt_q    <= '0;
			open_q   <= 1'b0;
			chw_q    <= '0;
			ptr_q    <= '0;
			stp_q    <= '0;
			pend_q   <= '0;
			chr_q    <= '0;
			rsn_q    <= '0;
			held_q   <= '0;
			held_v_q <= 1'b0;
			older_q  <= 1'b0;
			rst_q    <= ST_OK;
			rch_q    <= '0;
		end else begin
			state_q  <= state_d;
			ins_q    <= ins_d;
			brw_q    <= brw_d;
			cnt_q    <= cnt_d;
			open_q   <= open_d;
			chw_q    <= chw_d;
			ptr_q    <= ptr_d;
			stp_q    <= stp_d;
			pend_q   <= pend_d;
			chr_q    <= chr_d;
			rsn_q    <= rsn_d;
			held_q   <= held_d;
			held_v_q <= held_v_d;
			older_q  <= older_d;
			rst_q    <= rst_d;
			rch_q    <= rch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mrc_q <= MRC_RESET;
		else if (cfg_we)
			mrc_q <= cfg_wdata;
	end

	// one valid bit per ring byte; clear wipes them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (clr_all)
				valid_q <= '0;
			else if (mem_wr_en)
				valid_q[mem_wr_addr] <= 1'b1;
			if (mem_rd_en)
				vld_s1 <= valid_q[mem_rd_addr];
		end
	end

	always_comb begin
		state_d     = state_q;
		ins_d       = ins_q;
		brw_d       = brw_q;
		cnt_d       = cnt_q;
		open_d      = open_q;
		chw_d       = chw_q;
		ptr_d       = ptr_q;
		stp_d       = stp_q;
		pend_d      = pend_q;
		chr_d       = chr_q;
		rsn_d       = rsn_q;
		held_d      = held_q;
		held_v_d    = held_v_q;
		older_d     = older_q;
		rst_d       = rst_q;
		rch_d       = rch_q;
		in_ready    = 1'b0;
		clr_all     = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = ins_q;
		mem_wr_data = MARK_END;
		res_valid   = 1'b0;
		res         = '{status: rst_q, char_out: rch_q, last: 1'b1};
		pend_nx     = pend_q;
		advance     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				rst_d    = ST_OK;
				rch_d    = 8'h00;
				if (in_valid) begin
					if (in_cmd == CMD_APPEND) begin
						// a dropped, non-final character touches nothing
						pend_nx = {in_eos, !open_q || (chw_q < CHR_MAX), !open_q};
						pend_d  = pend_nx;
						chr_d   = sanitize(in_char);
						state_d = (pend_nx != '0) ? S_APP_RD : S_RESP;
					end else if (open_q) begin
						rst_d   = ST_BUSY;
						state_d = S_RESP;
					end else begin
						state_d = S_RESP;
						unique case (in_cmd) inside
							CMD_OLDER, CMD_NEWER: begin
								if (cnt_q == '0) begin
									rst_d = ST_NONE;
								end else begin
									older_d = (in_cmd == CMD_OLDER);
									ptr_d   = brw_q;
									stp_d   = '0;
									state_d = S_WALK_RD;
								end
							end
							CMD_RD_CHAR: begin
								if (cnt_q == '0) begin
									rst_d = ST_NONE;
								end else begin
									mem_rd_en   = 1'b1;
									mem_rd_addr = ring_wrap(SUM_W'(brw_q) + SUM_W'(1)
										+ SUM_W'(in_off));
									state_d     = S_RCH_CK;
								end
							end
							CMD_RD_STR: begin
								if (cnt_q == '0 || mrc_q <= MRC_W'(1)) begin
									rst_d = ST_NONE;
								end else begin
									ptr_d    = ring_next(brw_q);
									rsn_d    = '0;
									held_v_d = 1'b0;
									state_d  = S_RS_RD;
								end
							end
							CMD_CLEAR: begin
								clr_all = 1'b1;
								ins_d   = '0;
								brw_d   = '0;
								cnt_d   = '0;
								chw_d   = '0;
							end
							default: ;
						endcase
					end
				end
			end

			S_APP_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = ins_q;
				state_d     = S_APP_WR;
			end

			// write the first pending byte, counting a lost START
			S_APP_WR: begin
				mem_wr_en = 1'b1;
				ins_d     = ring_next(ins_q);
				cnt_d     = cnt_dec;
				if (pend_q[0]) begin
					mem_wr_data = MARK_START;
					brw_d       = ins_q;
					open_d      = 1'b1;
					chw_d       = '0;
					pend_nx[0]  = 1'b0;
				end else if (pend_q[1]) begin
					mem_wr_data = chr_q;
					chw_d       = chw_q + AW'(1);
					pend_nx[1]  = 1'b0;
				end else begin
					mem_wr_data = MARK_END;
					cnt_d       = cnt_dec + CNT_W'(1);
					open_d      = 1'b0;
					chw_d       = '0;
					pend_nx[2]  = 1'b0;
				end
				pend_d  = pend_nx;
				state_d = (pend_nx != '0) ? S_APP_RD : S_RESP;
			end

			S_WALK_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = step_addr;
				ptr_d       = step_addr;
				stp_d       = stp_q + STP_W'(1);
				state_d     = S_WALK_CK;
			end

			S_WALK_CK: begin
				if (rbyte == MARK_START) begin
					brw_d   = ptr_q;
					state_d = S_RESP;
				end else if (stp_q == STP_W'(RING_BYTES)) begin
					rst_d   = ST_NONE;
					state_d = S_RESP;
				end else begin
					state_d = S_WALK_RD;
				end
			end

			S_RCH_CK: begin
				if (rbyte == MARK_END)
					rst_d = ST_NONE;
				else
					rch_d = rbyte;
				state_d = S_RESP;
			end

			S_RS_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = ptr_q;
				ptr_d       = ring_next(ptr_q);
				rsn_d       = rsn_q + MRC_W'(1);
				state_d     = S_RS_CK;
			end

			// a character is held back one step so the last one can be marked
			S_RS_CK: begin
				if (rbyte == MARK_END) begin
					res_valid = 1'b1;
					if (held_v_q)
						res = '{status: ST_OK, char_out: held_q, last: 1'b1};
					else
						res = '{status: ST_NONE, char_out: 8'h00, last: 1'b1};
					if (res_ready)
						state_d = S_IDLE;
				end else begin
					if (held_v_q) begin
						res_valid = 1'b1;
						res       = '{status: ST_OK, char_out: held_q, last: 1'b0};
					end
					advance = !held_v_q || res_ready;
					if (advance) begin
						held_d   = rbyte;
						held_v_d = 1'b1;
						state_d  = (rsn_q == limit) ? S_RS_FIN : S_RS_RD;
					end
				end
			end

			S_RS_FIN: begin
				res_valid = 1'b1;
				res       = '{status: ST_OK, char_out: held_q, last: 1'b1};
				if (res_ready)
					state_d = S_IDLE;
			end

			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/dshr_obuf.sv]
// Output register of the result stream; parts the sequencer from the consumer.
// Uses dshr_pkg for the result type and stream widths.
`default_nettype none

module dshr_obuf
	import dshr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_valid,
	output logic                      res_ready,
	input  wire res_t                 res,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,
	output logic      [M_TUSER_W-1:0] m_tuser,
	output logic                      m_tlast
);

	logic valid_q;
	res_t res_q;

	assign res_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (res_ready)
			valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.char_out;
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule

`default_nettype wire

[rtl/core/dshr_checker.sv]
// Port-level checker for the string history ring, bound to the top level.
// Uses dshr_pkg and the assertion macros header.
`default_nettype none

`include "delimited_string_history_ring_macros.svh"

module dshr_port_checker
	import dshr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser,
	input wire logic                 m_tlast
);

	logic [M_TDATA_W+M_TUSER_W:0] m_word;

	assign m_word = {m_tlast, m_tuser, m_tdata};

	// hold a stalled result transaction
	`DSHR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

	// a failed answer carries no character
	`DSHR_ASSERT_IMP(a_fail_no_char, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)

	// a failed answer always ends its command
	`DSHR_ASSERT_IMP(a_fail_is_last, m_tvalid && (m_tuser != ST_OK), m_tlast)

endmodule

bind delimited_string_history_ring dshr_port_checker u_dshr_port_checker (.*);

`default_nettype wire
